### rtl/qat_pkg.sv
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and character codes for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package qat_pkg;

  // character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // most results one byte can cause
  localparam int MAX_RES = 3;

  // one result, without the end-of-run flag
  typedef struct packed {
    logic       kind;
    logic [7:0] char_out;
    logic [7:0] token_index;
    logic       is_command;
  } qat_res_t;

  // all results of one byte, as queued between front and back
  typedef struct packed {
    logic [1:0]                 count;
    qat_res_t [MAX_RES-1:0]     res;
  } qat_bundle_t;

  // append one result to a bundle
  function automatic qat_bundle_t qat_emit(qat_bundle_t b, logic kind, logic [7:0] ch,
                                           logic cmd, logic [7:0] cnt);
    qat_bundle_t nb;
    qat_res_t    r;
    nb            = b;
    r.kind        = kind;
    r.char_out    = ch;
    r.token_index = cmd ? 8'd0 : cnt;
    r.is_command  = cmd;
    if (nb.count != 2'd3) begin
      nb.res[nb.count] = r;
      nb.count         = nb.count + 2'd1;
    end
    return nb;
  endfunction

endpackage

`default_nettype wire

### rtl/qat_ifs.sv
// ----------------------------------------------------------------------------
// qat channel interfaces
// Valid/ready channels for configuration, input bytes and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface qat_cfg_if;
  logic valid;
  logic ready;
  logic first_is_command;
  modport source(output valid, output first_is_command, input ready);
  modport sink(input valid, input first_is_command, output ready);
endinterface

interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_string;
  modport source(output valid, output char_in, output end_of_string, input ready);
  modport sink(input valid, input char_in, input end_of_string, output ready);
endinterface

interface qat_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_out;
  logic [7:0] token_index;
  logic       is_command;
  logic       last_of_run;
  modport source(output valid, output kind, output char_out, output token_index,
                 output is_command, output last_of_run, input ready);
  modport sink(input valid, input kind, input char_out, input token_index,
               input is_command, input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/quoted_argument_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_unit
// Shell-style argument splitter: bytes in, token characters and end marks out.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one byte per transfer, end_of_string set on the last byte.
//   out_chan : token characters (kind 0) and token end marks (kind 1), each
//              with token_index, is_command and last_of_run; a byte gives
//              zero to three results.
//   cfg_chan : first_is_command, always ready; write it while the unit is
//              idle.
// Timing:
//   a byte is classified in the cycle it transfers; its results pass through
//   the bundle queue and then the output register.
//   one byte per cycle enters while the queue has room; results leave one per
//   cycle while out_chan.ready is high. The queue of QUEUE_DEPTH bundles lets
//   the front run ahead while the back drains longer runs.
// Reset: synchronous, clears tokenizer state, the queue and first_is_command.
// Stall: when out_chan.ready is low the output register holds, the queue
//   fills, and in_chan.ready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module quoted_argument_tokenizer_unit
  import qat_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qat_cfg_if.sink    cfg_chan,
  qat_in_if.sink     in_chan,
  qat_out_if.source  out_chan
);

  logic        push_valid, push_ready;
  qat_bundle_t push_data;
  logic        pop_valid, pop_ready;
  qat_bundle_t pop_data;

  // configuration is always taken
  assign cfg_chan.ready = 1'b1;

  // classification and state
  qat_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_chan.valid),
    .cfg_first_is_command (cfg_chan.first_is_command),
    .in_valid             (in_chan.valid),
    .in_ready             (in_chan.ready),
    .char_in              (in_chan.char_in),
    .end_of_string        (in_chan.end_of_string),
    .push_valid           (push_valid),
    .push_ready           (push_ready),
    .push_data            (push_data)
  );

  // bundle queue
  qat_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // result serializer
  qat_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .kind        (out_chan.kind),
    .char_out    (out_chan.char_out),
    .token_index (out_chan.token_index),
    .is_command  (out_chan.is_command),
    .last_of_run (out_chan.last_of_run)
  );

endmodule

`default_nettype wire

### rtl/qat_front.sv
// ----------------------------------------------------------------------------
// qat_front
// Classifies each byte, updates the tokenizer state and builds the bundle of
// results the byte causes, all in the cycle the byte transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_front
  import qat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_first_is_command,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  char_in,
  input  wire logic        end_of_string,
  output logic             push_valid,
  input  wire logic        push_ready,
  output qat_bundle_t      push_data
);

  logic       fic_r;
  logic       in_token_r, in_token_nxt;
  logic       in_quotes_r, in_quotes_nxt;
  logic       esc_r, esc_nxt;
  logic       qdbl_r, qdbl_nxt;
  logic       held_r, held_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       cmd_taken_r, cmd_taken_nxt;
  logic       accept;

  assign in_ready   = push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = in_valid && (push_data.count != 2'd0);

  // step through one byte as the sequence of held, process and end-of-string
  always_comb begin
    logic        it, iq, ep, qd, hb, ct, run;
    logic [7:0]  cnt, c, open_q;
    logic        is_sep, is_quote;
    qat_bundle_t b;
    it  = in_token_r;
    iq  = in_quotes_r;
    ep  = esc_r;
    qd  = qdbl_r;
    hb  = held_r;
    ct  = cmd_taken_r;
    cnt = cnt_r;
    c   = char_in;
    b   = '0;
    run = 1'b1;
    open_q   = qd ? CH_DQUOTE : CH_SQUOTE;
    is_sep   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
    is_quote = (c == CH_SQUOTE) || (c == CH_DQUOTE);

    // resolve a backslash held inside quotes
    if (hb) begin
      hb = 1'b0;
      if (c == open_q) begin
        b   = qat_emit(b, KIND_CHAR, c, fic_r && !ct, cnt);
        run = 1'b0;
      end else begin
        b = qat_emit(b, KIND_CHAR, CH_BSLASH, fic_r && !ct, cnt);
      end
    end

    // classify the byte
    if (run) begin
      if (ep) begin
        ep = 1'b0;
        it = 1'b1;
        b  = qat_emit(b, KIND_CHAR, c, fic_r && !ct, cnt);
      end else if (iq) begin
        if (c == CH_BSLASH) begin
          hb = 1'b1;
        end else if (c == open_q) begin
          b = qat_emit(b, KIND_END, 8'd0, fic_r && !ct, cnt);
          if (fic_r && !ct) ct = 1'b1;
          else if (cnt != 8'hFF) cnt = cnt + 8'd1;
          it = 1'b0;
          iq = 1'b0;
        end else begin
          b = qat_emit(b, KIND_CHAR, c, fic_r && !ct, cnt);
        end
      end else if (is_sep) begin
        if (it) begin
          b = qat_emit(b, KIND_END, 8'd0, fic_r && !ct, cnt);
          if (fic_r && !ct) ct = 1'b1;
          else if (cnt != 8'hFF) cnt = cnt + 8'd1;
          it = 1'b0;
          iq = 1'b0;
        end
      end else if (is_quote) begin
        if (!it) begin
          it = 1'b1;
          iq = 1'b1;
          qd = (c == CH_DQUOTE);
        end
      end else if (c == CH_BSLASH) begin
        ep = 1'b1;
      end else begin
        it = 1'b1;
        b  = qat_emit(b, KIND_CHAR, c, fic_r && !ct, cnt);
      end
    end

    // end of string flushes and clears
    if (end_of_string) begin
      if (hb) b = qat_emit(b, KIND_CHAR, CH_BSLASH, fic_r && !ct, cnt);
      if (it) b = qat_emit(b, KIND_END, 8'd0, fic_r && !ct, cnt);
      it  = 1'b0;
      iq  = 1'b0;
      ep  = 1'b0;
      qd  = 1'b0;
      hb  = 1'b0;
      cnt = 8'd0;
      ct  = 1'b0;
    end

    push_data     = b;
    in_token_nxt  = it;
    in_quotes_nxt = iq;
    esc_nxt       = ep;
    qdbl_nxt      = qd;
    held_nxt      = hb;
    cnt_nxt       = cnt;
    cmd_taken_nxt = ct;
  end

  // tokenizer state and configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fic_r       <= 1'b0;
      in_token_r  <= 1'b0;
      in_quotes_r <= 1'b0;
      esc_r       <= 1'b0;
      qdbl_r      <= 1'b0;
      held_r      <= 1'b0;
      cnt_r       <= 8'd0;
      cmd_taken_r <= 1'b0;
    end else begin
      if (cfg_we) fic_r <= cfg_first_is_command;
      if (accept) begin
        in_token_r  <= in_token_nxt;
        in_quotes_r <= in_quotes_nxt;
        esc_r       <= esc_nxt;
        qdbl_r      <= qdbl_nxt;
        held_r      <= held_nxt;
        cnt_r       <= cnt_nxt;
        cmd_taken_r <= cmd_taken_nxt;
      end
    end
  end

`ifndef SYNTH
  a_held_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> in_quotes_r) else $error("held backslash outside quotes");
  a_esc_not_quoted: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> !in_quotes_r) else $error("escape pending inside quotes");
  a_quotes_in_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_quotes_r |-> in_token_r) else $error("quoted state without open token");
`endif

endmodule

`default_nettype wire

### rtl/qat_fifo.sv
// ----------------------------------------------------------------------------
// qat_fifo
// Short queue of result bundles between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_fifo
  import qat_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push_valid,
  output logic              push_ready,
  input  wire qat_bundle_t  push_data,
  output logic              pop_valid,
  input  wire logic         pop_ready,
  output qat_bundle_t       pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  qat_bundle_t   mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/qat_back.sv
// ----------------------------------------------------------------------------
// qat_back
// Unpacks queued bundles into single results and loads them into the output
// register, one per cycle while the register is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_back
  import qat_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         pop_valid,
  output logic              pop_ready,
  input  wire qat_bundle_t  pop_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic              kind,
  output logic [7:0]        char_out,
  output logic [7:0]        token_index,
  output logic              is_command,
  output logic              last_of_run
);

  logic       out_valid_r;
  qat_res_t   res_r;
  logic       last_r;
  logic [1:0] sub_r;
  logic       load;
  logic       is_last;

  assign load      = pop_valid && (!out_valid_r || out_ready);
  assign is_last   = (sub_r == pop_data.count - 2'd1);
  assign pop_ready = load && is_last;

  assign out_valid   = out_valid_r;
  assign kind        = res_r.kind;
  assign char_out    = res_r.char_out;
  assign token_index = res_r.token_index;
  assign is_command  = res_r.is_command;
  assign last_of_run = last_r;

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= pop_data.res[sub_r];
      last_r <= is_last;
    end
  end

  // output valid and position within the bundle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 2'd0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sub_r       <= is_last ? 2'd0 : sub_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_sub_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_r != 2'd0) |-> pop_valid) else $error("partial bundle without queue head");
  a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sub_r != 2'd0) |-> (sub_r < pop_data.count)) else $error("result slot past bundle");
  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid |-> (pop_data.count != 2'd0)) else $error("empty bundle queued");
`endif

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the quoted argument tokenizer against a cycle-free model of its token
// rules. Bytes go in through the input channel, token characters and end marks
// come back on the result channel and are compared field by field, in order.
// A short table of corner cases runs first, then random strings under four
// idle and stall patterns, with the command flag toggled between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import qat_pkg::*;

  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int PRINT_CAP    = 40;
  localparam int PHASE_ITEMS  = 60;
  localparam int LONG_TOKENS  = 40;

  // one token result as seen on the result channel
  typedef struct packed {
    logic       kind;
    logic [7:0] char_out;
    logic [7:0] token_index;
    logic       is_command;
    logic       last_of_run;
  } tok_result_t;

  // one row of the corner-case table; res is used only when typed is set
  typedef struct {
    logic [7:0]  ch;
    logic        eos;
    bit          typed;
    int          n;
    tok_result_t res;
  } stim_row_t;

  localparam tok_result_t NO_RES = '0;

  logic clk;
  logic rst_n;

  qat_cfg_if cfg_bus ();
  qat_in_if  in_bus ();
  qat_out_if out_bus ();

  quoted_argument_tokenizer_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_bus),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // tokenizer model state
  logic       cfg_first_cmd;
  logic       st_in_token;
  logic       st_in_quotes;
  logic       st_escape;
  logic       st_dquote;
  logic       st_held_bs;
  logic       st_cmd_taken;
  logic [7:0] st_count;

  tok_result_t step_res[$];
  tok_result_t pending_results[$];
  logic [7:0]  text_bytes[$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // corner cases, starting from reset with the command flag clear
  stim_row_t directed_rows [0:25] = '{
    '{8'h61,     1'b0, 1'b1, 1, '{KIND_CHAR, 8'h61, 8'd0, 1'b0, 1'b1}},
    '{8'hFF,     1'b0, 1'b1, 1, '{KIND_CHAR, 8'hFF, 8'd0, 1'b0, 1'b1}},
    '{CH_SPACE,  1'b0, 1'b1, 1, '{KIND_END,  8'h00, 8'd0, 1'b0, 1'b1}},
    '{8'h00,     1'b0, 1'b1, 1, '{KIND_CHAR, 8'h00, 8'd1, 1'b0, 1'b1}},
    '{CH_DQUOTE, 1'b0, 1'b1, 0, NO_RES},  // quote inside a bare token drops
    '{CH_TAB,    1'b0, 1'b1, 1, '{KIND_END,  8'h00, 8'd1, 1'b0, 1'b1}},
    '{CH_SQUOTE, 1'b0, 1'b1, 0, NO_RES},  // opens a single-quoted token
    '{CH_SPACE,  1'b0, 1'b0, 0, NO_RES},
    '{CH_DQUOTE, 1'b0, 1'b0, 0, NO_RES},
    '{CH_BSLASH, 1'b0, 1'b1, 0, NO_RES},  // held until the next byte
    '{CH_SQUOTE, 1'b0, 1'b0, 0, NO_RES},  // escaped opening quote
    '{CH_BSLASH, 1'b0, 1'b1, 0, NO_RES},
    '{8'h78,     1'b0, 1'b0, 0, NO_RES},  // held backslash flushed first
    '{CH_SQUOTE, 1'b0, 1'b0, 0, NO_RES},
    '{CH_BSLASH, 1'b0, 1'b1, 0, NO_RES},  // bare escape starts nothing
    '{CH_SPACE,  1'b0, 1'b0, 0, NO_RES},  // escaped separator starts token
    '{CH_BSLASH, 1'b0, 1'b1, 0, NO_RES},
    '{CH_BSLASH, 1'b0, 1'b0, 0, NO_RES},
    '{CH_NL,     1'b0, 1'b0, 0, NO_RES},
    '{CH_DQUOTE, 1'b0, 1'b0, 0, NO_RES},
    '{CH_DQUOTE, 1'b0, 1'b0, 0, NO_RES},  // empty quoted token
    '{CH_DQUOTE, 1'b0, 1'b0, 0, NO_RES},
    '{CH_BSLASH, 1'b1, 1'b0, 0, NO_RES},  // quoted backslash at end of string
    '{CH_BSLASH, 1'b1, 1'b1, 0, NO_RES},  // bare backslash at end is dropped
    '{CH_SQUOTE, 1'b0, 1'b0, 0, NO_RES},
    '{8'h80,     1'b1, 1'b0, 0, NO_RES}   // unclosed quote closed at end
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic is_separator(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

  function automatic logic is_special(logic [7:0] c);
    return is_separator(c) || (c == CH_SQUOTE) || (c == CH_DQUOTE) || (c == CH_BSLASH);
  endfunction

  // model: append one result for this byte
  function automatic void add_result(logic kind, logic [7:0] ch);
    tok_result_t r;
    logic        cmd;
    cmd           = cfg_first_cmd && !st_cmd_taken;
    r.kind        = kind;
    r.char_out    = ch;
    r.token_index = cmd ? 8'd0 : st_count;
    r.is_command  = cmd;
    r.last_of_run = 1'b0;
    step_res      = {step_res, r};
  endfunction

  function automatic void close_token();
    add_result(KIND_END, 8'h00);
    if (cfg_first_cmd && !st_cmd_taken) begin
      st_cmd_taken = 1'b1;
    end else if (st_count != 8'hFF) begin
      st_count = st_count + 8'd1;
    end
    st_in_token  = 1'b0;
    st_in_quotes = 1'b0;
  endfunction

  function automatic void clear_tokenizer();
    st_in_token  = 1'b0;
    st_in_quotes = 1'b0;
    st_escape    = 1'b0;
    st_dquote    = 1'b0;
    st_held_bs   = 1'b0;
    st_count     = 8'd0;
    st_cmd_taken = 1'b0;
  endfunction

  // model: one byte with no held backslash in front of it
  function automatic void scan_byte(logic [7:0] c);
    logic [7:0] open_q;
    open_q = st_dquote ? CH_DQUOTE : CH_SQUOTE;
    if (st_escape) begin
      st_escape   = 1'b0;
      st_in_token = 1'b1;
      add_result(KIND_CHAR, c);
    end else if (st_in_quotes) begin
      if (c == CH_BSLASH) st_held_bs = 1'b1;
      else if (c == open_q) close_token();
      else add_result(KIND_CHAR, c);
    end else if (is_separator(c)) begin
      if (st_in_token) close_token();
    end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
      if (!st_in_token) begin
        st_in_token  = 1'b1;
        st_in_quotes = 1'b1;
        st_dquote    = (c == CH_DQUOTE);
      end
    end else if (c == CH_BSLASH) begin
      st_escape = 1'b1;
    end else begin
      st_in_token = 1'b1;
      add_result(KIND_CHAR, c);
    end
  endfunction

  // model: all results caused by one accepted byte, into step_res
  function automatic void tokenize_byte(logic [7:0] c, logic eos);
    logic [7:0]  open_q;
    step_res.delete();
    open_q = st_dquote ? CH_DQUOTE : CH_SQUOTE;
    if (st_held_bs) begin
      st_held_bs = 1'b0;
      if (c == open_q) begin
        add_result(KIND_CHAR, c);
      end else begin
        add_result(KIND_CHAR, CH_BSLASH);
        scan_byte(c);
      end
    end else begin
      scan_byte(c);
    end
    // end of string closes an open token once, then everything clears
    if (eos) begin
      if (st_held_bs) add_result(KIND_CHAR, CH_BSLASH);
      if (st_in_token) close_token();
      clear_tokenizer();
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last_of_run = 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // one byte transfer; the model runs at the accepting edge
  task automatic send_byte(input logic [7:0] ch, input logic eos, input bit typed = 1'b0,
                           input int n = 0, input tok_result_t res = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.char_in       <= ch;
    in_bus.end_of_string <= eos;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tokenize_byte(ch, eos);
    if (typed) begin
      if (n > 0) pending_results = {pending_results, res};
    end else begin
      pending_results = {pending_results, step_res};
    end
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
    text_bytes.delete();
  endtask

  // wait for every result, then let the pipeline empty out
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_first_cmd(input logic value);
    cfg_bus.valid            <= 1'b1;
    cfg_bus.first_is_command <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_first_cmd = value;
    cfg_bus.valid <= 1'b0;
  endtask

  // add one byte to the string being built
  function automatic void put_text(logic [7:0] c);
    text_bytes = {text_bytes, c};
  endfunction

  // random byte pickers
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (is_special(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic logic [7:0] sep_char();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] any_quote();
    return $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
  endfunction

  // bare word with the odd escape and stray quote
  function automatic void append_word(int len);
    int pick;
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        put_text(CH_BSLASH);
        put_text(8'($urandom_range(255)));
      end else if (pick == 1 && i > 0) begin
        put_text(any_quote());
      end else begin
        put_text(plain_char());
      end
    end
  endfunction

  // quoted token, usually closed
  function automatic void append_quoted();
    logic [7:0] q;
    logic [7:0] c;
    int         pick;
    q = any_quote();
    put_text(q);
    repeat ($urandom_range(5)) begin
      pick = $urandom_range(19);
      if (pick < 3) begin
        put_text(CH_BSLASH);
        put_text(q);
      end else if (pick < 6) begin
        put_text(CH_BSLASH);
        c = 8'($urandom_range(255));
        while (c == q) c = 8'($urandom_range(255));
        put_text(c);
      end else if (pick < 8) begin
        put_text((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
      end else if (pick < 10) begin
        put_text(sep_char());
      end else begin
        c = 8'($urandom_range(255));
        while (c == q || c == CH_BSLASH) c = 8'($urandom_range(255));
        put_text(c);
      end
    end
    if ($urandom_range(9) != 0) put_text(q);
  endfunction

  // command line with random content
  task automatic send_string();
    int ntok;
    ntok = $urandom_range(1, 6);
    if ($urandom_range(4) == 0) put_text(sep_char());
    for (int t = 0; t < ntok; t++) begin
      if (t > 0) repeat ($urandom_range(1, 2)) put_text(sep_char());
      case ($urandom_range(3))
        0: append_quoted();
        1: begin
          put_text(CH_BSLASH);
          put_text(8'($urandom_range(255)));
          append_word($urandom_range(3));
        end
        default: append_word($urandom_range(1, 5));
      endcase
    end
    case ($urandom_range(9))
      0:       put_text(CH_BSLASH);
      1:       put_text(sep_char());
      default: ;
    endcase
    send_text();
  endtask

  // raw bytes with a rare end flag
  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  // one long string of short tokens back to back
  task automatic send_long_string();
    for (int t = 0; t < LONG_TOKENS; t++) begin
      put_text(plain_char());
      put_text(sep_char());
    end
    send_text();
  endtask

  // result side: check each transfer, then pick the next ready
  initial begin
    tok_result_t want;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0b char=%02h index=%0d",
                                    out_bus.kind, out_bus.char_out, out_bus.token_index));
        end else begin
          want = pending_results.pop_front();
          if (out_bus.kind !== want.kind)
            report_mismatch($sformatf("kind %b, expected %b", out_bus.kind, want.kind));
          if (out_bus.char_out !== want.char_out)
            report_mismatch($sformatf("char_out %02h, expected %02h",
                                      out_bus.char_out, want.char_out));
          if (out_bus.token_index !== want.token_index)
            report_mismatch($sformatf("token_index %0d, expected %0d",
                                      out_bus.token_index, want.token_index));
          if (out_bus.is_command !== want.is_command)
            report_mismatch($sformatf("is_command %b, expected %b",
                                      out_bus.is_command, want.is_command));
          if (out_bus.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, expected %b",
                                      out_bus.last_of_run, want.last_of_run));
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // main sequence
  initial begin
    rst_n                    <= 1'b0;
    in_bus.valid             <= 1'b0;
    in_bus.char_in           <= 8'h00;
    in_bus.end_of_string     <= 1'b0;
    cfg_bus.valid            <= 1'b0;
    cfg_bus.first_is_command <= 1'b0;
    cfg_first_cmd = 1'b0;
    clear_tokenizer();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner-case table
    foreach (directed_rows[i])
      send_byte(directed_rows[i].ch, directed_rows[i].eos, directed_rows[i].typed,
                directed_rows[i].n, directed_rows[i].res);

    // random phases: none, sender idle, receiver stall, both
    for (int phase_idx = 0; phase_idx < 4; phase_idx++) begin
      int phase_target;
      settle();
      write_first_cmd(phase_idx % 2 == 0);
      send_idle_pct  = (phase_idx == 1) ? 64 : (phase_idx == 3) ? 15 : 0;
      recv_stall_pct = (phase_idx == 2) ? 64 : (phase_idx == 3) ? 15 : 0;
      if (phase_idx == 0) send_long_string();
      phase_target = items_sent + PHASE_ITEMS;
      while (items_sent < phase_target) begin
        if ($urandom_range(99) < 15) send_noise();
        else send_string();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
